/* design/pdcch_ue_search_space_core_defines.svh */
// Assertion macros for the PDCCH UE search space core.
// Depends on clk_i and rst_ni in the module that uses them.
`ifndef PDCCH_UE_SEARCH_SPACE_CORE_DEFINES_SVH
`define PDCCH_UE_SEARCH_SPACE_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PDCCH_SS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PDCCH_SS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pdcch_ss_pkg.sv */
// Package for the PDCCH UE search space core: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps

package pdcch_ss_pkg;

  localparam int unsigned RNTI_W  = 16;
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned SF_W    = 4;
  localparam int unsigned CCE_W   = 7;
  localparam int unsigned CAND_W  = 3;
  localparam int unsigned Y_W     = 17;
  localparam int unsigned PROD_W  = 33;
  localparam int unsigned BIT_W   = 5;

  localparam logic [15:0]      HASH_A      = 16'd39827;
  localparam logic [Y_W:0]     HASH_D      = 18'd65537;
  localparam logic [SF_W-1:0]  SF_PER_FRAME = 4'd10;
  localparam logic [CCE_W-1:0] MIN_CCES    = 7'd8;
  localparam logic [BIT_W-1:0] DIV_LAST_BIT = 5'(Y_W - 1);

  localparam logic [LEVEL_W-1:0] LVL_1 = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_2 = 2'd1;

  localparam logic [CAND_W-1:0] CAND_SMALL_LVL = 3'd6;
  localparam logic [CAND_W-1:0] CAND_LARGE_LVL = 3'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hash_last;
    logic div_last;
    logic cand_last;
    logic out_free;
  } status_t;

  function automatic logic [CAND_W-1:0] cand_count(logic [LEVEL_W-1:0] lvl);
    return (lvl inside {LVL_1, LVL_2}) ? CAND_SMALL_LVL : CAND_LARGE_LVL;
  endfunction

endpackage

/* design/pdcch_ss_if.sv */
// Channel interfaces for the PDCCH UE search space core.
// Depends on pdcch_ss_pkg for field widths.
`timescale 1ns / 1ps

interface pdcch_ss_in_if;
  logic                              valid;
  logic                              ready;
  logic [pdcch_ss_pkg::RNTI_W-1:0]   rnti;
  logic [pdcch_ss_pkg::LEVEL_W-1:0]  aggregation_level;
  logic [pdcch_ss_pkg::SF_W-1:0]     subframe;
  modport source (output valid, rnti, aggregation_level, subframe, input ready);
  modport sink   (input valid, rnti, aggregation_level, subframe, output ready);
endinterface

interface pdcch_ss_out_if;
  logic                              valid;
  logic                              ready;
  logic [pdcch_ss_pkg::CCE_W-1:0]    cce_start;
  logic [pdcch_ss_pkg::CAND_W-1:0]   candidate_index;
  logic                              last_candidate;
  modport source (output valid, cce_start, candidate_index, last_candidate, input ready);
  modport sink   (input valid, cce_start, candidate_index, last_candidate, output ready);
endinterface

interface pdcch_ss_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pdcch_ss_pkg::CCE_W-1:0]    total_cces;
  modport source (output valid, total_cces, input ready);
  modport sink   (input valid, total_cces, output ready);
endinterface

/* design/pdcch_ue_search_space_core.sv */
// PDCCH UE-specific search space: a request takes an RNTI, an aggregation
// level and a subframe and returns the start CCE of each candidate, lowest
// candidate first, with last_candidate on the final one. There are 6
// candidates for levels 1 and 2 and 2 for levels 4 and 8. The hash runs
// k + 1 modular multiplies, one per cycle, where k = subframe mod 10, the
// reduction mod floor(N/L) runs a restoring divider one dividend bit per
// cycle, and candidates leave one per cycle while the output is not stalled.
// The next request is taken while the last candidate waits in the output
// register. Write total_cces only while idle; values below 8 are stored as 8.
// Reset sets it to 8.
// Depends on pdcch_ss_pkg, pdcch_ss_if, pdcch_ss_ctrl, pdcch_ss_datapath.
`timescale 1ns / 1ps

module pdcch_ue_search_space_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  pdcch_ss_cfg_if.sink cfg_i,
  pdcch_ss_in_if.sink  in_i,
  pdcch_ss_out_if.source out_o
);

  pdcch_ss_pkg::cmd_t    cmd;
  pdcch_ss_pkg::status_t status;
  logic                  in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  pdcch_ss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pdcch_ss_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .rnti_i              (in_i.rnti),
    .aggregation_level_i (in_i.aggregation_level),
    .subframe_i          (in_i.subframe),
    .cfg_valid_i         (cfg_i.valid),
    .cfg_total_cces_i    (cfg_i.total_cces),
    .out_ready_i         (out_o.ready),
    .out_valid_o         (out_o.valid),
    .cce_start_o         (out_o.cce_start),
    .candidate_index_o   (out_o.candidate_index),
    .last_candidate_o    (out_o.last_candidate)
  );

endmodule

/* design/pdcch_ss_datapath.sv */
// Datapath: CCE count register, hash multiply-reduce, restoring divider,
// candidate stepping and output register. Depends on pdcch_ss_pkg.
`timescale 1ns / 1ps

module pdcch_ss_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pdcch_ss_pkg::cmd_t                  cmd_i,
  output pdcch_ss_pkg::status_t               status_o,
  input  logic [pdcch_ss_pkg::RNTI_W-1:0]     rnti_i,
  input  logic [pdcch_ss_pkg::LEVEL_W-1:0]    aggregation_level_i,
  input  logic [pdcch_ss_pkg::SF_W-1:0]       subframe_i,
  input  logic                                cfg_valid_i,
  input  logic [pdcch_ss_pkg::CCE_W-1:0]      cfg_total_cces_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [pdcch_ss_pkg::CCE_W-1:0]      cce_start_o,
  output logic [pdcch_ss_pkg::CAND_W-1:0]     candidate_index_o,
  output logic                                last_candidate_o
);

  logic [pdcch_ss_pkg::CCE_W-1:0]   total_cces_q, total_cces_d;
  logic [pdcch_ss_pkg::Y_W-1:0]     y_q, y_d;
  logic [pdcch_ss_pkg::LEVEL_W-1:0] lvl_q;
  logic [pdcch_ss_pkg::SF_W-1:0]    iter_q, iter_d;
  logic [pdcch_ss_pkg::BIT_W-1:0]   bit_q, bit_d;
  logic [pdcch_ss_pkg::CCE_W-1:0]   rem_q, rem_d;
  logic [pdcch_ss_pkg::CAND_W-1:0]  cand_q, cand_d;
  logic                             out_valid_q, out_valid_d;
  logic [pdcch_ss_pkg::CCE_W-1:0]   cce_q;
  logic [pdcch_ss_pkg::CAND_W-1:0]  cand_out_q;
  logic                             last_q;

  logic [pdcch_ss_pkg::SF_W-1:0]    k;
  logic [pdcch_ss_pkg::PROD_W-1:0]  prod;
  logic [pdcch_ss_pkg::Y_W:0]       fold;
  logic [pdcch_ss_pkg::Y_W-1:0]     y_mod;
  logic [pdcch_ss_pkg::CCE_W-1:0]   t;
  logic [pdcch_ss_pkg::CCE_W:0]     rem_sh;
  logic [pdcch_ss_pkg::CCE_W-1:0]   rem_div;
  logic [pdcch_ss_pkg::CCE_W:0]     rem_inc;
  logic                             cand_last;

  assign total_cces_d = (cfg_total_cces_i < pdcch_ss_pkg::MIN_CCES)
                        ? pdcch_ss_pkg::MIN_CCES : cfg_total_cces_i;

  assign k = (subframe_i >= pdcch_ss_pkg::SF_PER_FRAME)
             ? subframe_i - pdcch_ss_pkg::SF_PER_FRAME : subframe_i;

  // 2^16 = -1 mod 65537: fold the product as lo - mid + top
  assign prod  = pdcch_ss_pkg::PROD_W'(y_q) * pdcch_ss_pkg::PROD_W'(pdcch_ss_pkg::HASH_A);
  assign fold  = 18'(prod[15:0]) + 18'(prod[32]) - 18'(prod[31:16]);
  assign y_mod = fold[17] ? 17'(fold + pdcch_ss_pkg::HASH_D) : fold[16:0];

  assign t       = total_cces_q >> lvl_q;
  assign rem_sh  = {rem_q, y_q[pdcch_ss_pkg::Y_W-1]};
  assign rem_div = (rem_sh >= {1'b0, t}) ? 7'(rem_sh - {1'b0, t}) : rem_sh[6:0];
  assign rem_inc = {1'b0, rem_q} + 8'd1;

  assign cand_last = (cand_q == pdcch_ss_pkg::cand_count(lvl_q) - 3'd1);

  always_comb begin
    y_d         = y_q;
    iter_d      = iter_q;
    bit_d       = bit_q;
    rem_d       = rem_q;
    cand_d      = cand_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      y_d    = {1'b0, rnti_i};
      iter_d = k;
    end
    if (cmd_i.hash_step) begin
      y_d    = y_mod;
      iter_d = iter_q - 4'd1;
    end
    if (cmd_i.div_init) begin
      rem_d  = '0;
      bit_d  = pdcch_ss_pkg::DIV_LAST_BIT;
      cand_d = '0;
    end
    if (cmd_i.div_step) begin
      y_d   = {y_q[pdcch_ss_pkg::Y_W-2:0], 1'b0};
      rem_d = rem_div;
      bit_d = bit_q - 5'd1;
    end
    if (cmd_i.emit) begin
      rem_d       = (rem_inc == {1'b0, t}) ? '0 : rem_inc[6:0];
      cand_d      = cand_q + 3'd1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_cces_q <= pdcch_ss_pkg::MIN_CCES;
      iter_q       <= '0;
      bit_q        <= '0;
      cand_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        total_cces_q <= total_cces_d;
      end
      iter_q      <= iter_d;
      bit_q       <= bit_d;
      cand_q      <= cand_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      lvl_q <= aggregation_level_i;
    end
    if (cmd_i.emit) begin
      cce_q      <= rem_q << lvl_q;
      cand_out_q <= cand_q;
      last_q     <= cand_last;
    end
  end

  assign status_o.hash_last = (iter_q == '0);
  assign status_o.div_last  = (bit_q == '0);
  assign status_o.cand_last = cand_last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign cce_start_o       = cce_q;
  assign candidate_index_o = cand_out_q;
  assign last_candidate_o  = last_q;

endmodule

/* design/pdcch_ss_ctrl.sv */
// Controller: sequences load, hash, divide and emit phases of one request.
// Depends on pdcch_ss_pkg and pdcch_ue_search_space_core_defines.svh.
`timescale 1ns / 1ps
`include "pdcch_ue_search_space_core_defines.svh"

module pdcch_ss_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pdcch_ss_pkg::status_t status_i,
  output pdcch_ss_pkg::cmd_t    cmd_o
);

  pdcch_ss_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pdcch_ss_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pdcch_ss_pkg::ST_HASH;
        end
      end
      pdcch_ss_pkg::ST_HASH: begin
        if (status_i.hash_last) begin
          state_d = pdcch_ss_pkg::ST_DIV;
        end
      end
      pdcch_ss_pkg::ST_DIV: begin
        if (status_i.div_last) begin
          state_d = pdcch_ss_pkg::ST_EMIT;
        end
      end
      pdcch_ss_pkg::ST_EMIT: begin
        if (status_i.out_free && status_i.cand_last) begin
          state_d = pdcch_ss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pdcch_ss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    case (state_q)
      pdcch_ss_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pdcch_ss_pkg::ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        cmd_o.div_init  = status_i.hash_last;
      end
      pdcch_ss_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      pdcch_ss_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdcch_ss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PDCCH_SS_ASSERT_IMP(a_emit_free, cmd_o.emit, status_i.out_free, "emit into occupied output")
  `PDCCH_SS_ASSERT_NXT(a_load_hash, in_valid_i && in_ready_o,
                       state_q == pdcch_ss_pkg::ST_HASH, "accepted request did not start hash")
  `PDCCH_SS_ASSERT_NXT(a_last_idle, cmd_o.emit && status_i.cand_last,
                       state_q == pdcch_ss_pkg::ST_IDLE, "no return to idle after last candidate")

endmodule

/* dv/pdcch_ue_search_space_core_tb.sv */
// Testbench for pdcch_ue_search_space_core: random and directed UE requests,
// an own predictor of the candidate start CCEs, and a scoreboard on the output.
// Depends on pdcch_ss_pkg, pdcch_ss_if and the core RTL.
`timescale 1ns / 1ps

module pdcch_ue_search_space_core_tb;

  localparam logic [pdcch_ss_pkg::LEVEL_W-1:0] LVL_4 = 2'd2;
  localparam logic [pdcch_ss_pkg::LEVEL_W-1:0] LVL_8 = 2'd3;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned PHASE_ITEMS = 73;
  localparam int unsigned NUM_PHASES = 6;

  typedef struct packed {
    logic [pdcch_ss_pkg::RNTI_W-1:0]  rnti;
    logic [pdcch_ss_pkg::LEVEL_W-1:0] level;
    logic [pdcch_ss_pkg::SF_W-1:0]    subframe;
  } ue_req_t;

  typedef struct packed {
    logic [pdcch_ss_pkg::CCE_W-1:0]  cce_start;
    logic [pdcch_ss_pkg::CAND_W-1:0] candidate_index;
    logic                            last_candidate;
  } cand_t;

  logic clk_i;
  logic rst_ni;

  pdcch_ss_cfg_if cfg_if ();
  pdcch_ss_in_if  req_if ();
  pdcch_ss_out_if cand_if ();

  pdcch_ue_search_space_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (req_if),
    .out_o  (cand_if)
  );

  ue_req_t                        ue_request_q[$];
  cand_t                          cand_expected_q[$];
  logic [pdcch_ss_pkg::CCE_W-1:0] cce_total = pdcch_ss_pkg::MIN_CCES;
  logic                           req_fire = 1'b0;
  int unsigned                    mismatch_count = 0;
  int unsigned                    idle_cycles = 0;
  int unsigned                    gap_max = 0;
  int unsigned                    gap_left = 0;
  int unsigned                    burst_left = 1;
  int unsigned                    rx_cycle = 0;
  int unsigned                    stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void add_request(ue_req_t r);
    ue_request_q.insert(ue_request_q.size(), r);
  endfunction

  function automatic void add_expected(cand_t c);
    cand_expected_q.insert(cand_expected_q.size(), c);
  endfunction

  function automatic void predict_candidates(ue_req_t req);
    logic [pdcch_ss_pkg::Y_W-1:0]    y;
    logic [pdcch_ss_pkg::PROD_W-1:0] prod;
    logic [pdcch_ss_pkg::SF_W-1:0]   k;
    int unsigned                     span;
    int unsigned                     count;
    int unsigned                     slots;
    cand_t                           c;
    k = req.subframe % pdcch_ss_pkg::SF_PER_FRAME;
    y = pdcch_ss_pkg::Y_W'(req.rnti);
    for (int s = 0; s <= int'(k); s++) begin
      prod = y * pdcch_ss_pkg::HASH_A;
      y = pdcch_ss_pkg::Y_W'(prod % pdcch_ss_pkg::HASH_D);
    end
    span = 1 << req.level;
    count = (req.level == pdcch_ss_pkg::LVL_1 || req.level == pdcch_ss_pkg::LVL_2)
            ? pdcch_ss_pkg::CAND_SMALL_LVL : pdcch_ss_pkg::CAND_LARGE_LVL;
    slots = cce_total / span;
    for (int m = 0; m < count; m++) begin
      c.cce_start = pdcch_ss_pkg::CCE_W'(span * ((int'(y) + m) % slots));
      c.candidate_index = pdcch_ss_pkg::CAND_W'(m);
      c.last_candidate = (m + 1 == count);
      add_expected(c);
    end
  endfunction

  function automatic ue_req_t random_ue_req();
    ue_req_t r;
    case ($urandom_range(0, 15))
      0:       r.rnti = '0;
      1:       r.rnti = '1;
      default: r.rnti = pdcch_ss_pkg::RNTI_W'($urandom_range(0, 65535));
    endcase
    r.level = pdcch_ss_pkg::LEVEL_W'($urandom_range(0, 3));
    r.subframe = ($urandom_range(0, 4) == 0) ? pdcch_ss_pkg::SF_W'($urandom_range(10, 15))
                                             : pdcch_ss_pkg::SF_W'($urandom_range(0, 9));
    return r;
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (ue_request_q.size() != 0 || req_if.valid || cand_expected_q.size() != 0);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_total_cces(logic [pdcch_ss_pkg::CCE_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.total_cces <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cce_total = (value < pdcch_ss_pkg::MIN_CCES) ? pdcch_ss_pkg::MIN_CCES : value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Request driver: bursts with random gaps.
  always @(negedge clk_i) begin
    ue_req_t req;
    if (rst_ni && (!req_if.valid || req_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (ue_request_q.size() > 0) begin
        req = ue_request_q.pop_front();
        req_if.rnti <= req.rnti;
        req_if.aggregation_level <= req.level;
        req_if.subframe <= req.subframe;
        req_if.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(0, gap_max);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Candidate receiver: always ready, random stalls, then long stalls.
  always @(negedge clk_i) begin
    rx_cycle++;
    case ((rx_cycle / 300) % 3)
      0: cand_if.ready <= 1'b1;
      1: cand_if.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          cand_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 20);
          cand_if.ready <= 1'b0;
        end else begin
          cand_if.ready <= 1'b1;
        end
      end
    endcase
  end

  // Scoreboard and watchdog.
  always @(posedge clk_i) begin
    cand_t want;
    logic  got_req;
    logic  got_cand;
    got_req = rst_ni && req_if.valid && req_if.ready;
    got_cand = rst_ni && cand_if.valid && cand_if.ready;
    req_fire <= got_req;
    if (got_req) begin
      predict_candidates('{req_if.rnti, req_if.aggregation_level, req_if.subframe});
    end
    if (got_cand) begin
      if (cand_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected candidate cce=%0d m=%0d last=%0b",
                                  cand_if.cce_start, cand_if.candidate_index,
                                  cand_if.last_candidate));
      end else begin
        want = cand_expected_q.pop_front();
        if (cand_if.cce_start !== want.cce_start)
          report_mismatch($sformatf("cce_start got %0d exp %0d (m=%0d)",
                                    cand_if.cce_start, want.cce_start, want.candidate_index));
        if (cand_if.candidate_index !== want.candidate_index)
          report_mismatch($sformatf("candidate_index got %0d exp %0d",
                                    cand_if.candidate_index, want.candidate_index));
        if (cand_if.last_candidate !== want.last_candidate)
          report_mismatch($sformatf("last_candidate got %0b exp %0b (m=%0d)",
                                    cand_if.last_candidate, want.last_candidate,
                                    want.candidate_index));
      end
    end
    if (got_req || got_cand || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [pdcch_ss_pkg::CCE_W-1:0] cfg_plan[NUM_PHASES];
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.total_cces = '0;
    req_if.valid = 1'b0;
    req_if.rnti = '0;
    req_if.aggregation_level = '0;
    req_if.subframe = '0;
    cand_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset value of the CCE count.
    gap_max = 4;
    add_request('{16'd1, pdcch_ss_pkg::LVL_1, 4'd0});
    add_request('{16'hFFFF, LVL_8, 4'd9});
    add_request('{16'd0, pdcch_ss_pkg::LVL_2, 4'd5});
    add_request('{16'd12345, LVL_4, 4'd10});
    add_request('{16'd54321, pdcch_ss_pkg::LVL_1, 4'd15});
    wait_drained();

    // Count below the minimum saturates.
    write_total_cces(7'd0);
    add_request('{16'hAAAA, LVL_8, 4'd3});
    add_request('{16'h5555, LVL_4, 4'd4});
    wait_drained();

    write_total_cces(7'd127);
    add_request('{16'hFFFF, pdcch_ss_pkg::LVL_1, 4'd9});
    add_request('{16'd1, pdcch_ss_pkg::LVL_2, 4'd0});
    add_request('{16'd0, LVL_4, 4'd15});
    add_request('{16'd40000, LVL_8, 4'd12});
    add_request('{16'hFFFF, LVL_8, 4'd0});
    add_request('{16'd2, pdcch_ss_pkg::LVL_1, 4'd7});
    add_request('{16'hFFFF, pdcch_ss_pkg::LVL_2, 4'd15});
    wait_drained();

    cfg_plan = '{7'd127, 7'd7, pdcch_ss_pkg::CCE_W'($urandom_range(8, 127)), 7'd0,
                 pdcch_ss_pkg::CCE_W'($urandom_range(0, 127)), 7'd8};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_total_cces(cfg_plan[p]);
      case (p % 3)
        0:       gap_max = 0;
        1:       gap_max = 4;
        default: gap_max = 40;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        add_request(random_ue_req());
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
